>>> src/ttd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants for the touch tap detector: arithmetic widths,
// screen limits, tap timing limits, register indexes and the control
// interface between the controller and the datapath.
// ----------------------------------------------------------------------------
package ttd_pkg;

   // Field widths.
   localparam int TimeW  = 32;
   localparam int CountW = 8;
   localparam int ByteW  = 8;
   localparam int RawW   = 12;
   localparam int ColW   = 8;
   localparam int RowW   = 9;
   localparam int CsrIdxW = 3;

   // Arithmetic widths: difference and span (13-bit signed), product
   // (22-bit signed), quotient magnitude (21 bits), signed result (24 bits).
   localparam int SpanW = RawW + 1;
   localparam int ProdW = 22;
   localparam int QuotW = 21;
   localparam int ResW  = 24;
   localparam int CntW  = $clog2(QuotW);

   // Screen geometry.
   localparam logic signed [ProdW-1:0] ColsProd = ProdW'(240);
   localparam logic signed [ProdW-1:0] RowsProd = ProdW'(320);
   localparam logic signed [ResW-1:0]  ColMax   = ResW'(239);
   localparam logic signed [ResW-1:0]  RowMax   = ResW'(319);

   // Tap timing in milliseconds.
   localparam logic [TimeW-1:0] TapMinMs = TimeW'(30);
   localparam logic [TimeW-1:0] TapMaxMs = TimeW'(1000);
   localparam logic [TimeW-1:0] TapGapMs = TimeW'(100);

   // Touch count codes that mean touched.
   localparam logic [CountW-1:0] CountOne = CountW'(1);
   localparam logic [CountW-1:0] CountTwo = CountW'(2);

   // Raw high byte carries coordinate bits 11..8 in its low nibble.
   localparam int HighNibbleW = 4;

   // Register indexes.
   localparam logic [CsrIdxW-1:0] CsrXSpanLow  = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrXSpanHigh = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrYSpanLow  = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrYSpanHigh = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrSwapAxes  = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrMirrorX   = 3'd5;
   localparam logic [CsrIdxW-1:0] CsrMirrorY   = 3'd6;

   // Register reset values.
   localparam logic [RawW-1:0] XSpanHighReset = RawW'(240);
   localparam logic [RawW-1:0] YSpanHighReset = RawW'(320);

   // Controller states.
   typedef enum logic [5:0] {
      StIdle   = 6'b000001,
      StPrep   = 6'b000010,
      StLoad   = 6'b000100,
      StDivide = 6'b001000,
      StFix    = 6'b010000,
      StFinish = 6'b100000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic prep;
      logic load;
      logic step;
      logic fix;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rising;
      logic out_free;
   } status_type;

endpackage

>>> src/ttd_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_div_lane
// One shift-subtract divider lane: signed product over signed span,
// truncated toward zero, one quotient bit per step. A zero span reads as 0.
// ----------------------------------------------------------------------------
module ttd_div_lane
   import ttd_pkg::*;
(
   input  logic                    clock,
   input  logic                    load,
   input  logic                    step,
   input  logic signed [ProdW-1:0] prod,
   input  logic signed [SpanW-1:0] span,
   output logic signed [ResW-1:0]  result
);

   logic [QuotW-1:0] quot_ff, quot_in;
   logic [RawW-1:0]  rem_ff, rem_in;
   logic [RawW-1:0]  den_ff, den_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;

   logic [ProdW-1:0] prod_abs;
   logic [SpanW-1:0] span_abs;
   logic [RawW:0]    rem_shift;
   logic [RawW:0]    rem_diff;

   // Magnitudes of the operands at load time.
   assign prod_abs = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
   assign span_abs = span[SpanW-1] ? SpanW'(-span) : SpanW'(span);

   // Restoring step: shift in the next dividend bit and subtract if it fits.
   assign rem_shift = {rem_ff, quot_ff[QuotW-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (load) begin
         quot_in = prod_abs[QuotW-1:0];
         rem_in  = '0;
         den_in  = span_abs[RawW-1:0];
         neg_in  = prod[ProdW-1] ^ span[SpanW-1];
         zero_in = (span == '0);
      end else if (step) begin
         if (!rem_diff[RawW]) begin
            rem_in  = rem_diff[RawW-1:0];
            quot_in = {quot_ff[QuotW-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[RawW-1:0];
            quot_in = {quot_ff[QuotW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // Apply the sign of the quotient; a zero span gives zero.
   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (neg_ff) begin
         result = -$signed({{(ResW-QuotW){1'b0}}, quot_ff});
      end else begin
         result = $signed({{(ResW-QuotW){1'b0}}, quot_ff});
      end
   end

endmodule

>>> src/ttd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_datapath
// Configuration registers, sample capture, scaling by two divider lanes,
// mirror and clamp, press and tap timing state, and the result register.
// ----------------------------------------------------------------------------
module ttd_datapath
   import ttd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [RawW-1:0]    csr_wdata,
   input  logic [TimeW-1:0]   req_now_ms,
   input  logic [CountW-1:0]  req_touch_count,
   input  logic [ByteW-1:0]   req_x_high_byte,
   input  logic [ByteW-1:0]   req_x_low_byte,
   input  logic [ByteW-1:0]   req_y_high_byte,
   input  logic [ByteW-1:0]   req_y_low_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_tap_seen,
   output logic [ColW-1:0]    rsp_tap_x,
   output logic [RowW-1:0]    rsp_tap_y
);

   // Configuration registers.
   logic [RawW-1:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff;
   logic            swap_ff, mirror_x_ff, mirror_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_lo_ff     <= '0;
         x_hi_ff     <= XSpanHighReset;
         y_lo_ff     <= '0;
         y_hi_ff     <= YSpanHighReset;
         swap_ff     <= 1'b0;
         mirror_x_ff <= 1'b0;
         mirror_y_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CsrXSpanLow:  x_lo_ff     <= csr_wdata;
            CsrXSpanHigh: x_hi_ff     <= csr_wdata;
            CsrYSpanLow:  y_lo_ff     <= csr_wdata;
            CsrYSpanHigh: y_hi_ff     <= csr_wdata;
            CsrSwapAxes:  swap_ff     <= csr_wdata[0];
            CsrMirrorX:   mirror_x_ff <= csr_wdata[0];
            CsrMirrorY:   mirror_y_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Sample capture; raw points are unpacked and swapped here.
   logic [TimeW-1:0] now_ff;
   logic             touched_ff;
   logic [RawW-1:0]  ax_ff, ay_ff;
   logic [RawW-1:0]  raw_x, raw_y;

   assign raw_x = {req_x_high_byte[HighNibbleW-1:0], req_x_low_byte};
   assign raw_y = {req_y_high_byte[HighNibbleW-1:0], req_y_low_byte};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff     <= req_now_ms;
         touched_ff <= (req_touch_count == CountOne) || (req_touch_count == CountTwo);
         ax_ff      <= swap_ff ? raw_y : raw_x;
         ay_ff      <= swap_ff ? raw_x : raw_y;
      end
   end

   // Press tracking state.
   logic             was_touched_ff;
   logic [TimeW-1:0] press_start_ff;
   logic [TimeW-1:0] last_tap_ff;
   logic [ColW-1:0]  held_x_ff, held_x_in;
   logic [RowW-1:0]  held_y_ff, held_y_in;

   assign status.rising = touched_ff && !was_touched_ff;

   // Offset and span per axis, then the scaled product.
   logic signed [SpanW-1:0] diff_x, diff_y, span_x, span_y;
   logic signed [SpanW-1:0] span_x_ff, span_y_ff;
   logic signed [ProdW-1:0] prod_x_ff, prod_y_ff;

   assign diff_x = $signed({1'b0, ax_ff} - {1'b0, x_lo_ff});
   assign diff_y = $signed({1'b0, ay_ff} - {1'b0, y_lo_ff});
   assign span_x = $signed({1'b0, x_hi_ff} - {1'b0, x_lo_ff});
   assign span_y = $signed({1'b0, y_hi_ff} - {1'b0, y_lo_ff});

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         prod_x_ff <= ProdW'(diff_x) * ColsProd;
         prod_y_ff <= ProdW'(diff_y) * RowsProd;
         span_x_ff <= span_x;
         span_y_ff <= span_y;
      end
   end

   // Two divider lanes run side by side.
   logic signed [ResW-1:0] quot_x, quot_y;

   ttd_div_lane u_div_x (
      .clock  (clock),
      .load   (cmd.load),
      .step   (cmd.step),
      .prod   (prod_x_ff),
      .span   (span_x_ff),
      .result (quot_x)
   );

   ttd_div_lane u_div_y (
      .clock  (clock),
      .load   (cmd.load),
      .step   (cmd.step),
      .prod   (prod_y_ff),
      .span   (span_y_ff),
      .result (quot_y)
   );

   // Mirror and clamp each axis onto the screen.
   logic signed [ResW-1:0] mir_x, mir_y;

   always_comb begin
      mir_x = mirror_x_ff ? ColMax - quot_x : quot_x;
      mir_y = mirror_y_ff ? RowMax - quot_y : quot_y;
      if (mir_x < 0) begin
         held_x_in = '0;
      end else if (mir_x > ColMax) begin
         held_x_in = ColMax[ColW-1:0];
      end else begin
         held_x_in = mir_x[ColW-1:0];
      end
      if (mir_y < 0) begin
         held_y_in = '0;
      end else if (mir_y > RowMax) begin
         held_y_in = RowMax[RowW-1:0];
      end else begin
         held_y_in = mir_y[RowW-1:0];
      end
   end

   // Tap qualification on a release: press length and spacing since last tap.
   logic [TimeW-1:0] press_len, tap_gap;
   logic             tap_ok;

   assign press_len = now_ff - press_start_ff;
   assign tap_gap   = now_ff - last_tap_ff;
   assign tap_ok    = !touched_ff && was_touched_ff &&
                      (press_len >= TapMinMs) && (press_len <= TapMaxMs) &&
                      (tap_gap >= TapGapMs);

   always_ff @(posedge clock) begin
      if (reset) begin
         was_touched_ff <= 1'b0;
         press_start_ff <= '0;
         last_tap_ff    <= '0;
         held_x_ff      <= '0;
         held_y_ff      <= '0;
      end else begin
         if (cmd.fix) begin
            held_x_ff <= held_x_in;
            held_y_ff <= held_y_in;
         end
         if (cmd.finish) begin
            was_touched_ff <= touched_ff;
            if (status.rising) begin
               press_start_ff <= now_ff;
            end
            if (tap_ok) begin
               last_tap_ff <= now_ff;
            end
         end
      end
   end

   // Result register; a new item loads it once the last one is taken.
   logic            rsp_valid_ff;
   logic            seen_ff;
   logic [ColW-1:0] out_x_ff;
   logic [RowW-1:0] out_y_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         seen_ff  <= tap_ok;
         out_x_ff <= tap_ok ? held_x_ff : '0;
         out_y_ff <= tap_ok ? held_y_ff : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tap_seen = seen_ff;
   assign rsp_tap_x    = out_x_ff;
   assign rsp_tap_y    = out_y_ff;

endmodule

>>> src/ttd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_ctrl
// Controller: accepts one item at a time, sequences the scaling steps on a
// touch-down and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module ttd_ctrl
   import ttd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type       state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;

   assign req_stall = (state_ff != StIdle);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = StPrep;
            end
         end
         StPrep: begin
            cmd.prep = 1'b1;
            state_in = status.rising ? StLoad : StFinish;
         end
         StLoad: begin
            cmd.load = 1'b1;
            count_in = CntW'(QuotW - 1);
            state_in = StDivide;
         end
         StDivide: begin
            cmd.step = 1'b1;
            if (count_ff == '0) begin
               state_in = StFix;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         StFix: begin
            cmd.fix  = 1'b1;
            state_in = StFinish;
         end
         StFinish: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/touch_tap_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_detector_core
// Tap detector for touch poll samples with linear point calibration.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    now_ms, touch_count, four raw bytes
//   rsp      out        rsp_valid/stall    tap_seen, tap_x, tap_y
//   csr      in         csr_we             csr_index, csr_wdata
//
// A touch-down sample runs prep, load, the 21-step shift-subtract dividers
// (both axes run in parallel), fix and finish; any other sample goes from
// prep to finish. The controller is idle again once the result is loaded,
// so the next item is accepted even while that result waits at the output.
// Reset is synchronous and restores the register defaults and clears the
// press state. A stalled output holds the block in its last step.
// ----------------------------------------------------------------------------
module touch_tap_detector_core
   import ttd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [RawW-1:0]    csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [TimeW-1:0]   req_now_ms,
   input  logic [CountW-1:0]  req_touch_count,
   input  logic [ByteW-1:0]   req_x_high_byte,
   input  logic [ByteW-1:0]   req_x_low_byte,
   input  logic [ByteW-1:0]   req_y_high_byte,
   input  logic [ByteW-1:0]   req_y_low_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_tap_seen,
   output logic [ColW-1:0]    rsp_tap_x,
   output logic [RowW-1:0]    rsp_tap_y
);

   cmd_type    cmd;
   status_type status;

   ttd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ttd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_now_ms      (req_now_ms),
      .req_touch_count (req_touch_count),
      .req_x_high_byte (req_x_high_byte),
      .req_x_low_byte  (req_x_low_byte),
      .req_y_high_byte (req_y_high_byte),
      .req_y_low_byte  (req_y_low_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tap_seen    (rsp_tap_seen),
      .rsp_tap_x       (rsp_tap_x),
      .rsp_tap_y       (rsp_tap_y)
   );

endmodule
